FILE: rtl/twkp_pkg.sv
// Constants, tables and round functions of the keyless 64-bit permutation.
package twkp_pkg;

   localparam int ROUNDS  = 36;
   localparam int NIB_W   = 4;
   localparam int NIBBLES = 16;
   localparam int BLOCK_W = NIB_W * NIBBLES;

   typedef logic [BLOCK_W-1:0] block_type;
   typedef logic [NIB_W-1:0]   nibble_type;

   localparam nibble_type SBOX [NIBBLES] = '{
      4'hc, 4'h0, 4'hf, 4'ha, 4'h2, 4'hb, 4'h9, 4'h5,
      4'h8, 4'h3, 4'hd, 4'h7, 4'h1, 4'he, 4'h6, 4'h4
   };

   localparam nibble_type SHUF [NIBBLES] = '{
      4'd5, 4'd0, 4'd1, 4'd4, 4'd7, 4'd12, 4'd3, 4'd8,
      4'd13, 4'd6, 4'd9, 4'd2, 4'd15, 4'd10, 4'd11, 4'd14
   };

   // Each odd nibble is XORed with the S-box of the even nibble below it.
   function automatic block_type mix_odd(block_type blk);
      block_type res;
      res = blk;
      for (int j = 0; j < NIBBLES / 2; j++) begin
         res[(2*j+1)*NIB_W +: NIB_W] = blk[(2*j+1)*NIB_W +: NIB_W]
                                       ^ SBOX[blk[(2*j)*NIB_W +: NIB_W]];
      end
      return res;
   endfunction

   // Nibble h moves to position SHUF[h].
   function automatic block_type shuffle(block_type blk);
      block_type res;
      res = '0;
      for (int h = 0; h < NIBBLES; h++) begin
         res[SHUF[h]*NIB_W +: NIB_W] = blk[h*NIB_W +: NIB_W];
      end
      return res;
   endfunction

endpackage

FILE: rtl/twine_keyless_permutation.sv
// Top level: fully unrolled pipeline of the keyless 64-bit permutation.
//
// A transaction is accepted at a rising clock edge where start is high and
// busy is low. The block to permute is presented on req_block_in.
// Busy is high only while reset is asserted; otherwise a new transaction
// may be started in every cycle, so throughput is one block per cycle.
// Each round has a register stage of its own: a block accepted at a rising
// edge passes through every stage in turn and appears on rsp_block_out
// with rsp_valid high once the last stage has registered it.
// Each result stays on the result ports for exactly one cycle. The
// receiver cannot stall, and none is needed: results leave in the order
// their transactions were accepted, one per accepted block.
// The depth of one stage is one round: eight S-box lookups, eight XORs
// and, in every stage but the last, a fixed nibble shuffle.
// Synchronous reset clears all stage valid bits, so every transaction in
// flight is dropped and no result appears until a new one is accepted.
module twine_keyless_permutation (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [twkp_pkg::BLOCK_W-1:0]  req_block_in,
   output logic                          rsp_valid,
   output logic [twkp_pkg::BLOCK_W-1:0]  rsp_block_out
);

   logic                  valid_ff [twkp_pkg::ROUNDS];
   twkp_pkg::block_type   data_ff  [twkp_pkg::ROUNDS];
   logic                  valid_in [twkp_pkg::ROUNDS];
   twkp_pkg::block_type   data_in  [twkp_pkg::ROUNDS];
   twkp_pkg::block_type   stage_src [twkp_pkg::ROUNDS];
   logic                  accept;

   assign busy   = reset;
   assign accept = start && !busy;

   assign stage_src[0] = req_block_in;
   assign valid_in[0]  = accept;

   for (genvar s = 1; s < twkp_pkg::ROUNDS; s++) begin : g_link
      assign stage_src[s] = data_ff[s-1];
      assign valid_in[s]  = valid_ff[s-1];
   end

   for (genvar s = 0; s < twkp_pkg::ROUNDS; s++) begin : g_round
      if (s == twkp_pkg::ROUNDS - 1) begin : g_last
         assign data_in[s] = twkp_pkg::mix_odd(stage_src[s]);
      end else begin : g_full
         assign data_in[s] = twkp_pkg::shuffle(twkp_pkg::mix_odd(stage_src[s]));
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < twkp_pkg::ROUNDS; s++) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < twkp_pkg::ROUNDS; s++) begin
         data_ff[s] <= data_in[s];
      end
   end

   assign rsp_valid     = valid_ff[twkp_pkg::ROUNDS-1];
   assign rsp_block_out = data_ff[twkp_pkg::ROUNDS-1];

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(twkp_pkg::ROUNDS) rsp_valid)
      else $error("Accepted transaction gave no result after the pipeline latency.");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !accept |-> ##(twkp_pkg::ROUNDS) !rsp_valid)
      else $error("Result appeared without a matching accepted transaction.");

   a_reset_flush: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Result strobe high right after reset.");

endmodule
